// ===== hw/rtl/y2r_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the YUV 4:2:2 to RGB24 converter.
package y2r_pkg;

  // Byte order of one macropixel, as held in the configuration register.
  typedef enum logic {
    Y2R_ORDER_YUYV = 1'b0,
    Y2R_ORDER_UYVY = 1'b1
  } y2r_order_t;

  // Macropixel after byte-order classification.
  typedef struct packed {
    logic [7:0] y0;
    logic [7:0] y1;
    logic [7:0] u;
    logic [7:0] v;
    logic       frame_end;
  } y2r_item_t;

  // Two converted pixels plus the frame marker.
  typedef struct packed {
    logic [7:0] blue0;
    logic [7:0] green0;
    logic [7:0] red0;
    logic [7:0] blue1;
    logic [7:0] green1;
    logic [7:0] red1;
    logic       frame_end;
  } y2r_pix_t;

  localparam int Y2R_QUEUE_DEPTH = 2;

  // Chroma offset and fixed-point coefficients (scale 1/256).
  localparam logic signed [8:0] Y2R_CHROMA_OFS = 9'sd128;
  localparam logic signed [9:0] Y2R_K_CB       = 10'sd454;
  localparam logic signed [9:0] Y2R_K_CR       = 10'sd359;
  localparam logic signed [9:0] Y2R_K_CGU      = 10'sd88;
  localparam logic signed [9:0] Y2R_K_CGV      = 10'sd183;
  localparam logic signed [12:0] Y2R_PIX_MAX   = 13'sd255;

  // Saturate a signed sum to 0..255.
  function automatic logic [7:0] y2r_clamp8(input logic signed [12:0] val);
    logic [7:0] res;
    if (val < 13'sd0) begin
      res = 8'd0;
    end else if (val > Y2R_PIX_MAX) begin
      res = 8'd255;
    end else begin
      res = val[7:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/y2r_fifo.sv =====
`timescale 1ns / 1ps
// Small generic register-based FIFO used between front and back.
module y2r_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("fifo count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("fifo count did not advance on write");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("fifo pointers disagree with count");

endmodule

// ===== hw/rtl/y2r_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts macropixels and sorts the bytes into lumas and chromas.
module y2r_front (
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [7:0]            in_byte0,
  input  logic [7:0]            in_byte1,
  input  logic [7:0]            in_byte2,
  input  logic [7:0]            in_byte3,
  input  logic                  in_frame_end_in,
  input  y2r_pkg::y2r_order_t   byte_order,
  input  logic                  q_full,
  output logic                  q_push,
  output y2r_pkg::y2r_item_t    q_item
);
  import y2r_pkg::*;

  assign in_full = q_full;
  assign q_push  = in_push;

  always_comb begin
    q_item.frame_end = in_frame_end_in;
    case (byte_order)
      Y2R_ORDER_YUYV: begin
        q_item.y0 = in_byte0;
        q_item.u  = in_byte1;
        q_item.y1 = in_byte2;
        q_item.v  = in_byte3;
      end
      Y2R_ORDER_UYVY: begin
        q_item.u  = in_byte0;
        q_item.y0 = in_byte1;
        q_item.v  = in_byte2;
        q_item.y1 = in_byte3;
      end
      default: begin
        q_item.y0 = in_byte0;
        q_item.u  = in_byte1;
        q_item.y1 = in_byte2;
        q_item.v  = in_byte3;
      end
    endcase
  end

endmodule

// ===== hw/rtl/y2r_back.sv =====
`timescale 1ns / 1ps
// Back end: two-stage multiply / add-clamp pipeline feeding the result register.
module y2r_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  y2r_pkg::y2r_item_t  q_item,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output y2r_pkg::y2r_pix_t   out_pix
);
  import y2r_pkg::*;

  // Stage 1: chroma products.
  logic              s1_v_r, s1_v_nxt;
  logic signed [18:0] cb_p_r, cr_p_r, cgu_p_r, cgv_p_r;
  logic [7:0]        y0_r, y1_r;
  logic              fe_r;
  // Stage 2: result register.
  logic              s2_v_r, s2_v_nxt;
  y2r_pix_t          pix_r, pix_nxt;

  logic              s2_ready, s1_ready;
  logic signed [8:0] u_c, v_c;
  logic signed [18:0] cb_p, cr_p, cgu_p, cgv_p;
  logic signed [19:0] cg_sum;
  logic signed [12:0] cb_w, cr_w, cg_w, y0_w, y1_w;

  assign s2_ready = !s2_v_r || out_pop;
  assign s1_ready = !s1_v_r || s2_ready;
  assign q_pop    = s1_ready && !q_empty;

  assign u_c   = $signed({1'b0, q_item.u}) - Y2R_CHROMA_OFS;
  assign v_c   = $signed({1'b0, q_item.v}) - Y2R_CHROMA_OFS;
  assign cb_p  = u_c * Y2R_K_CB;
  assign cr_p  = v_c * Y2R_K_CR;
  assign cgu_p = u_c * Y2R_K_CGU;
  assign cgv_p = v_c * Y2R_K_CGV;

  // Arithmetic shift right by 8 is the upper bits of each product.
  assign cg_sum = 20'(cgu_p_r) + 20'(cgv_p_r);
  assign cb_w   = 13'($signed(cb_p_r[18:8]));
  assign cr_w   = 13'($signed(cr_p_r[18:8]));
  assign cg_w   = 13'($signed(cg_sum[19:8]));
  assign y0_w   = $signed({5'b0, y0_r});
  assign y1_w   = $signed({5'b0, y1_r});

  always_comb begin
    pix_nxt.blue0     = y2r_clamp8(y0_w + cb_w);
    pix_nxt.green0    = y2r_clamp8(y0_w - cg_w);
    pix_nxt.red0      = y2r_clamp8(y0_w + cr_w);
    pix_nxt.blue1     = y2r_clamp8(y1_w + cb_w);
    pix_nxt.green1    = y2r_clamp8(y1_w - cg_w);
    pix_nxt.red1      = y2r_clamp8(y1_w + cr_w);
    pix_nxt.frame_end = fe_r;
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    s2_v_nxt = s2_v_r;
    if (s1_ready) begin
      s1_v_nxt = q_pop;
    end
    if (s2_ready) begin
      s2_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cb_p_r  <= cb_p;
      cr_p_r  <= cr_p;
      cgu_p_r <= cgu_p;
      cgv_p_r <= cgv_p;
      y0_r    <= q_item.y0;
      y1_r    <= q_item.y1;
      fe_r    <= q_item.frame_end;
    end
    if (s2_ready && s1_v_r) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_empty = !s2_v_r;
  assign out_pix   = pix_r;

  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_ready) |=> s2_v_r)
    else $error("stage 1 item lost on advance");

  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> s1_v_r)
    else $error("queue read without stage 1 load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !out_pop) |=> (s2_v_r && $stable(pix_r)))
    else $error("pending result overwritten");

endmodule

// ===== hw/rtl/yuv422_to_rgb24_converter.sv =====
`timescale 1ns / 1ps
// A macropixel passes through the queue, the multiply stage and the result register to the out_ ports.
// Throughput: one macropixel per cycle, as long as out_pop does not hold back the result register.
// With out_pop low, QUEUE_DEPTH + 2 items are taken in (queue plus both stages) before full.
// Reset (rst_n low, synchronous) empties the queue and pipeline and sets byte_order to YUYV.
// The configuration channel is always ready; write it only while the block is idle.
module yuv422_to_rgb24_converter #(
  parameter int QUEUE_DEPTH = y2r_pkg::Y2R_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input macropixel channel.
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte0,
  input  logic [7:0] in_byte1,
  input  logic [7:0] in_byte2,
  input  logic [7:0] in_byte3,
  input  logic       in_frame_end_in,
  // Result channel.
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_blue0,
  output logic [7:0] out_green0,
  output logic [7:0] out_red0,
  output logic [7:0] out_blue1,
  output logic [7:0] out_green1,
  output logic [7:0] out_red1,
  output logic       out_frame_end_out,
  // Byte-order register write.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import y2r_pkg::*;

  y2r_order_t byte_order_r, byte_order_nxt;
  y2r_item_t  fr_item, q_item;
  y2r_pix_t   pix;
  logic       q_push, q_full, q_pop, q_empty;

  // Config register: a transfer needs only cfg_valid, bit 0 is the order.
  assign cfg_ready = 1'b1;

  always_comb begin
    byte_order_nxt = byte_order_r;
    if (cfg_valid && cfg_ready) begin
      byte_order_nxt = y2r_order_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_order_r <= Y2R_ORDER_YUYV;
    end else begin
      byte_order_r <= byte_order_nxt;
    end
  end

  // Front: byte-order sort, straight into the queue.
  y2r_front u_front (
    .in_push         (in_push),
    .in_full         (in_full),
    .in_byte0        (in_byte0),
    .in_byte1        (in_byte1),
    .in_byte2        (in_byte2),
    .in_byte3        (in_byte3),
    .in_frame_end_in (in_frame_end_in),
    .byte_order      (byte_order_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (fr_item)
  );

  // Decoupling queue between the front and the arithmetic back end.
  y2r_fifo #(
    .WIDTH ($bits(y2r_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (fr_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_item),
    .empty   (q_empty)
  );

  // Back: multiply stage, then add/clamp into the result register.
  y2r_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_pix   (pix)
  );

  assign out_blue0         = pix.blue0;
  assign out_green0        = pix.green0;
  assign out_red0          = pix.red0;
  assign out_blue1         = pix.blue1;
  assign out_green1        = pix.green1;
  assign out_red1          = pix.red1;
  assign out_frame_end_out = pix.frame_end;

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> (byte_order_r == y2r_order_t'($past(cfg_data))))
    else $error("byte order register missed a write");

  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_valid |=> $stable(byte_order_r))
    else $error("byte order changed without a write");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full && !q_pop) |=> in_full)
    else $error("queue drained without a read");

endmodule
